[rtl/rpt_pkg.sv]
// shared types and constants of the regex pattern tokenizer
// no dependencies
`timescale 1ns / 1ps

package rpt_pkg;

    typedef enum logic [3:0] {
        PH_IDLE, PH_ESC, PH_GROUP, PH_GROUP_ESC, PH_AFTER_LIT, PH_DASH,
        PH_RANGE_ESC, PH_QUANT, PH_OPT, PH_MIN, PH_MAX_START, PH_MAX
    } phase_t;

    localparam logic [2:0] KIND_LIT    = 3'd0;
    localparam logic [2:0] KIND_ANY    = 3'd1;
    localparam logic [2:0] KIND_END    = 3'd2;
    localparam logic [2:0] KIND_GROUP  = 3'd3;
    localparam logic [2:0] KIND_CHOICE = 3'd4;
    localparam logic [2:0] KIND_RANGE  = 3'd5;

    localparam logic [7:0] CH_CARET  = 8'h5e;
    localparam logic [7:0] CH_DOT    = 8'h2e;
    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_LBRACK = 8'h5b;
    localparam logic [7:0] CH_RBRACK = 8'h5d;
    localparam logic [7:0] CH_DASH   = 8'h2d;
    localparam logic [7:0] CH_SEMI   = 8'h3b;
    localparam logic [7:0] CH_QUEST  = 8'h3f;
    localparam logic [7:0] CH_STAR   = 8'h2a;
    localparam logic [7:0] CH_PLUS   = 8'h2b;
    localparam logic [7:0] CH_BSLASH = 8'h5c;

    // classified character, front to back
    typedef struct packed {
        logic [7:0] ch;
        logic       is_end;
        logic       is_dec;
        logic       is_hex;
        logic [3:0] digit;
    } cls_t;

    function automatic logic dec_f(input logic [7:0] c);
        return (c >= 8'h30) && (c <= 8'h39);
    endfunction

    function automatic logic hex_f(input logic [7:0] c);
        return dec_f(c) || ((c >= 8'h61) && (c <= 8'h66)) || ((c >= 8'h41) && (c <= 8'h46));
    endfunction

endpackage

[rtl/regex_pattern_tokenizer.sv]
// top level of the regex pattern tokenizer
// depends on rpt_pkg, rpt_front, rpt_queue, rpt_back
`timescale 1ns / 1ps

// Takes one pattern byte per transfer on s_axis (tuser high marks the end of
// the pattern) and returns regex tokens on m_axis, tlast on the last token that
// a pattern's end marker produces, if any. Sustained rate is one byte per
// cycle: the back end consumes a byte each cycle while its two-entry token
// buffer can take the results, and a byte producing two tokens holds the input
// until one drains. Bytes pass the front register and queue, tokens the buffer.
module regex_pattern_tokenizer #(
    parameter int OFFSET_BITS = 16,
    parameter int DEPTH_BITS  = 8,
    parameter int COUNT_BITS  = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,  // ch
    input  logic        s_axis_tuser,  // is_end
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // token_kind, negated, start_offset, token_length, min_count, max_count,
    // unbounded_max, zero pad
    output logic [71:0] m_axis_tdata,
    output logic        m_axis_tlast
);
    logic          f_valid, f_ready, b_valid, b_ready;
    rpt_pkg::cls_t f_data, b_data;
    logic [68:0]   tok;

    rpt_front u_front (
        .clk(clk), .rst_n(rst_n),
        .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
        .ch(s_axis_tdata), .is_end(s_axis_tuser),
        .q_valid(f_valid), .q_ready(f_ready), .q_data(f_data)
    );

    rpt_queue u_queue (
        .clk(clk), .rst_n(rst_n),
        .wr_valid(f_valid), .wr_ready(f_ready), .wr_data(f_data),
        .rd_valid(b_valid), .rd_ready(b_ready), .rd_data(b_data)
    );

    rpt_back #(
        .OFFSET_BITS(OFFSET_BITS), .DEPTH_BITS(DEPTH_BITS), .COUNT_BITS(COUNT_BITS)
    ) u_back (
        .clk(clk), .rst_n(rst_n),
        .q_valid(b_valid), .q_ready(b_ready), .q_data(b_data),
        .m_valid(m_axis_tvalid), .m_ready(m_axis_tready),
        .m_data(tok), .m_last(m_axis_tlast)
    );

    assign m_axis_tdata = {3'd0, tok};
endmodule

[rtl/rpt_front.sv]
// front part: input transfer, character classification
// depends on rpt_pkg
`timescale 1ns / 1ps

module rpt_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [7:0]        ch,
    input  logic              is_end,
    output logic              q_valid,
    input  logic              q_ready,
    output rpt_pkg::cls_t     q_data
);
    logic          valid_reg;
    rpt_pkg::cls_t data_reg;

    assign in_ready = !valid_reg || q_ready;
    assign q_valid  = valid_reg;
    assign q_data   = data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            data_reg.ch     <= ch;
            data_reg.is_end <= is_end;
            data_reg.is_dec <= rpt_pkg::dec_f(ch);
            data_reg.is_hex <= rpt_pkg::hex_f(ch);
            data_reg.digit  <= 4'(ch - 8'h30);
        end
    end
endmodule

[rtl/rpt_queue.sv]
// short queue between front and back
// depends on rpt_pkg
`timescale 1ns / 1ps

module rpt_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          wr_valid,
    output logic          wr_ready,
    input  rpt_pkg::cls_t wr_data,
    output logic          rd_valid,
    input  logic          rd_ready,
    output rpt_pkg::cls_t rd_data
);
    rpt_pkg::cls_t mem_reg [2];
    logic          wp_reg;
    logic          rp_reg;
    logic [1:0]    cnt_reg;
    logic          wr_en;
    logic          rd_en;

    assign wr_ready = cnt_reg != 2'd2;
    assign rd_valid = cnt_reg != 2'd0;
    assign rd_data  = mem_reg[rp_reg];
    assign wr_en    = wr_valid && wr_ready;
    assign rd_en    = rd_valid && rd_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            if (wr_en)
            begin
                wp_reg <= !wp_reg;
            end
            if (rd_en)
            begin
                rp_reg <= !rp_reg;
            end
            cnt_reg <= cnt_reg + {1'b0, wr_en} - {1'b0, rd_en};
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wp_reg] <= wr_data;
        end
    end
endmodule

[rtl/rpt_back.sv]
// back part: tokenizer state machine and two-entry result buffer
// depends on rpt_pkg
`timescale 1ns / 1ps

module rpt_back #(
    parameter int OFFSET_BITS = 16,
    parameter int DEPTH_BITS  = 8,
    parameter int COUNT_BITS  = 16
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          q_valid,
    output logic          q_ready,
    input  rpt_pkg::cls_t q_data,
    output logic          m_valid,
    input  logic          m_ready,
    output logic [68:0]   m_data,
    output logic          m_last
);
    localparam logic [OFFSET_BITS-1:0] OFF_MAX = '1;
    localparam logic [DEPTH_BITS-1:0]  DEP_MAX = '1;
    localparam logic [COUNT_BITS-1:0]  CNT_MAX = '1;

    typedef struct packed {
        logic [2:0]  kind;
        logic        neg;
        logic [15:0] start;
        logic [15:0] len;
        logic [15:0] mn;
        logic [15:0] mx;
        logic        unb;
        logic        last;
    } tok_t;

    rpt_pkg::phase_t           phase_reg, phase_next;
    logic [OFFSET_BITS-1:0]    pos_reg, pos_next;
    logic [2:0]                kind_reg, kind_next;
    logic                      neg_reg, neg_next;
    logic [OFFSET_BITS-1:0]    start_reg, start_next;
    logic [OFFSET_BITS-1:0]    len_reg, len_next;
    logic [DEPTH_BITS-1:0]     depth_reg, depth_next;
    logic                      hex_reg, hex_next;
    logic [COUNT_BITS-1:0]     acc_reg, acc_next;
    logic [COUNT_BITS-1:0]     min_reg, min_next;
    logic [COUNT_BITS-1:0]     max_reg, max_next;
    logic                      unb_reg, unb_next;

    tok_t       buf_reg [2];
    logic [1:0] cnt_reg;
    logic       rp_reg;
    tok_t       t0, t1;
    logic [1:0] nout;
    logic       take;

    assign q_ready = cnt_reg == 2'd0 || (cnt_reg == 2'd1 && m_ready);
    assign take    = q_valid && q_ready;
    assign m_valid = cnt_reg != 2'd0;
    assign m_data  = {buf_reg[rp_reg].unb, buf_reg[rp_reg].mx, buf_reg[rp_reg].mn,
                      buf_reg[rp_reg].len, buf_reg[rp_reg].start, buf_reg[rp_reg].neg,
                      buf_reg[rp_reg].kind};
    assign m_last  = buf_reg[rp_reg].last;

    function automatic logic [OFFSET_BITS-1:0] sadd(input logic [OFFSET_BITS-1:0] a,
                                                    input logic [1:0] b);
        logic [OFFSET_BITS:0] s;
        s = {1'b0, a} + {{(OFFSET_BITS-1){1'b0}}, b};
        return s[OFFSET_BITS] ? OFF_MAX : s[OFFSET_BITS-1:0];
    endfunction

    function automatic logic [COUNT_BITS-1:0] adig(input logic [COUNT_BITS-1:0] a,
                                                   input logic [3:0] d);
        logic [COUNT_BITS+4:0] v;
        v = {2'b00, a, 3'b000} + {4'b0000, a, 1'b0} + {{(COUNT_BITS+1){1'b0}}, d};
        return (v > {5'd0, CNT_MAX}) ? CNT_MAX : v[COUNT_BITS-1:0];
    endfunction

    function automatic logic [15:0] w16o(input logic [OFFSET_BITS-1:0] v);
        logic [OFFSET_BITS+15:0] e;
        e = {16'd0, v};
        return e[15:0];
    endfunction

    function automatic logic [15:0] w16c(input logic [COUNT_BITS-1:0] v);
        logic [COUNT_BITS+15:0] e;
        e = {16'd0, v};
        return e[15:0];
    endfunction

    always_comb
    begin
        logic [7:0]             c;
        logic                   again;
        logic                   emit;
        logic                   elast;
        logic [OFFSET_BITS-1:0] pos;
        logic [1:0]             n;
        tok_t                   tk;
        c = q_data.ch;
        phase_next = phase_reg;
        pos_next = pos_reg;
        kind_next = kind_reg;
        neg_next = neg_reg;
        start_next = start_reg;
        len_next = len_reg;
        depth_next = depth_reg;
        hex_next = hex_reg;
        acc_next = acc_reg;
        min_next = min_reg;
        max_next = max_reg;
        unb_next = unb_reg;
        t0 = '0;
        t1 = '0;
        n = 2'd0;
        pos = pos_reg;
        again = 1'b0;
        emit = 1'b0;
        elast = 1'b0;
        tk = '0;
        if (q_data.is_end)
        begin
            emit = 1'b1;
            elast = 1'b1;
            case (phase_reg)
                rpt_pkg::PH_IDLE:
                begin
                    emit = 1'b0;
                    if (neg_reg)
                    begin
                        t0 = '{rpt_pkg::KIND_LIT, 1'b1, w16o(pos_reg), 16'd1, 16'd1, 16'd1,
                               1'b0, 1'b1};
                        n = 2'd1;
                    end
                end
                rpt_pkg::PH_ESC:
                begin
                    if (!hex_reg)
                    begin
                        kind_next = rpt_pkg::KIND_END;
                        len_next = OFFSET_BITS'(1);
                    end
                end
                rpt_pkg::PH_DASH:
                begin
                    kind_next = rpt_pkg::KIND_LIT;
                    elast = 1'b0;
                end
                rpt_pkg::PH_RANGE_ESC:
                begin
                    if (!hex_reg)
                    begin
                        len_next = sadd(len_reg, 2'd2);
                    end
                end
                rpt_pkg::PH_MIN:
                begin
                    min_next = acc_reg;
                    max_next = acc_reg;
                end
                rpt_pkg::PH_MAX_START:
                begin
                    unb_next = 1'b1;
                end
                rpt_pkg::PH_MAX:
                begin
                    max_next = acc_reg;
                end
                default:
                begin
                end
            endcase
            if (emit)
            begin
                t0 = '{kind_next, neg_next, w16o(start_next), w16o(len_next), w16c(min_next),
                       w16c(max_next), unb_next, elast};
                n = 2'd1;
                if (phase_reg == rpt_pkg::PH_DASH)
                begin
                    t1 = '{rpt_pkg::KIND_LIT, 1'b0, w16o(pos_reg - OFFSET_BITS'(1)), 16'd1,
                           16'd1, 16'd1, 1'b0, 1'b1};
                    n = 2'd2;
                end
            end
            phase_next = rpt_pkg::PH_IDLE;
            pos_next = '0;
            kind_next = '0;
            neg_next = 1'b0;
            start_next = '0;
            len_next = '0;
            depth_next = '0;
            hex_next = 1'b0;
            acc_next = '0;
            min_next = COUNT_BITS'(1);
            max_next = COUNT_BITS'(1);
            unb_next = 1'b0;
        end
        else
        begin
            pos_next = sadd(pos_reg, 2'd1);
            for (int it = 0; it < 4; it++)
            begin
                if (it == 0 || again)
                begin
                    again = 1'b0;
                    emit = 1'b0;
                    case (phase_next)
                        rpt_pkg::PH_IDLE:
                        begin
                            if (c == rpt_pkg::CH_CARET && !neg_next)
                            begin
                                neg_next = 1'b1;
                            end
                            else
                            begin
                                start_next = pos;
                                case (c)
                                    rpt_pkg::CH_BSLASH:
                                    begin
                                        phase_next = rpt_pkg::PH_ESC;
                                        hex_next = 1'b0;
                                    end
                                    rpt_pkg::CH_DOT:
                                    begin
                                        kind_next = rpt_pkg::KIND_ANY;
                                        len_next = OFFSET_BITS'(1);
                                        phase_next = rpt_pkg::PH_QUANT;
                                    end
                                    rpt_pkg::CH_DOLLAR:
                                    begin
                                        kind_next = rpt_pkg::KIND_END;
                                        len_next = OFFSET_BITS'(1);
                                        phase_next = rpt_pkg::PH_QUANT;
                                    end
                                    rpt_pkg::CH_LPAREN, rpt_pkg::CH_LBRACK:
                                    begin
                                        kind_next = (c == rpt_pkg::CH_LPAREN) ?
                                            rpt_pkg::KIND_GROUP : rpt_pkg::KIND_CHOICE;
                                        start_next = sadd(pos, 2'd1);
                                        len_next = '0;
                                        depth_next = DEPTH_BITS'(1);
                                        phase_next = rpt_pkg::PH_GROUP;
                                    end
                                    default:
                                    begin
                                        kind_next = rpt_pkg::KIND_LIT;
                                        len_next = OFFSET_BITS'(1);
                                        phase_next = rpt_pkg::PH_AFTER_LIT;
                                    end
                                endcase
                            end
                        end
                        rpt_pkg::PH_ESC:
                        begin
                            if (!hex_next)
                            begin
                                len_next = OFFSET_BITS'(2);
                                if (q_data.is_hex)
                                begin
                                    hex_next = 1'b1;
                                end
                                else
                                begin
                                    phase_next = rpt_pkg::PH_AFTER_LIT;
                                end
                            end
                            else if (q_data.is_hex)
                            begin
                                len_next = OFFSET_BITS'(3);
                                phase_next = rpt_pkg::PH_AFTER_LIT;
                            end
                            else
                            begin
                                phase_next = rpt_pkg::PH_AFTER_LIT;
                                again = 1'b1;
                            end
                        end
                        rpt_pkg::PH_GROUP:
                        begin
                            if (c == rpt_pkg::CH_BSLASH)
                            begin
                                len_next = sadd(len_next, 2'd1);
                                phase_next = rpt_pkg::PH_GROUP_ESC;
                            end
                            else if ((kind_next == rpt_pkg::KIND_GROUP &&
                                      c == rpt_pkg::CH_LPAREN) ||
                                     (kind_next != rpt_pkg::KIND_GROUP &&
                                      c == rpt_pkg::CH_LBRACK))
                            begin
                                if (depth_next != DEP_MAX)
                                begin
                                    depth_next = depth_next + DEPTH_BITS'(1);
                                end
                                len_next = sadd(len_next, 2'd1);
                            end
                            else if ((kind_next == rpt_pkg::KIND_GROUP &&
                                      c == rpt_pkg::CH_RPAREN) ||
                                     (kind_next != rpt_pkg::KIND_GROUP &&
                                      c == rpt_pkg::CH_RBRACK))
                            begin
                                if (depth_next <= DEPTH_BITS'(1))
                                begin
                                    depth_next = '0;
                                    phase_next = rpt_pkg::PH_QUANT;
                                end
                                else
                                begin
                                    depth_next = depth_next - DEPTH_BITS'(1);
                                    len_next = sadd(len_next, 2'd1);
                                end
                            end
                            else
                            begin
                                len_next = sadd(len_next, 2'd1);
                            end
                        end
                        rpt_pkg::PH_GROUP_ESC:
                        begin
                            len_next = sadd(len_next, 2'd1);
                            phase_next = rpt_pkg::PH_GROUP;
                        end
                        rpt_pkg::PH_AFTER_LIT:
                        begin
                            if (c == rpt_pkg::CH_DASH)
                            begin
                                kind_next = rpt_pkg::KIND_RANGE;
                                phase_next = rpt_pkg::PH_DASH;
                            end
                            else
                            begin
                                phase_next = rpt_pkg::PH_QUANT;
                                again = 1'b1;
                            end
                        end
                        rpt_pkg::PH_DASH:
                        begin
                            if (c == rpt_pkg::CH_BSLASH)
                            begin
                                phase_next = rpt_pkg::PH_RANGE_ESC;
                                hex_next = 1'b0;
                            end
                            else
                            begin
                                len_next = sadd(len_next, 2'd2);
                                phase_next = rpt_pkg::PH_QUANT;
                            end
                        end
                        rpt_pkg::PH_RANGE_ESC:
                        begin
                            if (!hex_next)
                            begin
                                len_next = sadd(len_next, 2'd3);
                                if (q_data.is_hex)
                                begin
                                    hex_next = 1'b1;
                                end
                                else
                                begin
                                    phase_next = rpt_pkg::PH_QUANT;
                                end
                            end
                            else if (q_data.is_hex)
                            begin
                                len_next = sadd(len_next, 2'd1);
                                phase_next = rpt_pkg::PH_QUANT;
                            end
                            else
                            begin
                                phase_next = rpt_pkg::PH_QUANT;
                                again = 1'b1;
                            end
                        end
                        rpt_pkg::PH_QUANT:
                        begin
                            if (c == rpt_pkg::CH_SEMI)
                            begin
                                emit = 1'b1;
                            end
                            else if (c == rpt_pkg::CH_QUEST)
                            begin
                                min_next = '0;
                                phase_next = rpt_pkg::PH_OPT;
                            end
                            else if (q_data.is_dec)
                            begin
                                acc_next = adig('0, q_data.digit);
                                phase_next = rpt_pkg::PH_MIN;
                            end
                            else if (c == rpt_pkg::CH_STAR || c == rpt_pkg::CH_PLUS)
                            begin
                                if (c == rpt_pkg::CH_STAR)
                                begin
                                    min_next = '0;
                                end
                                phase_next = rpt_pkg::PH_MAX_START;
                            end
                            else
                            begin
                                emit = 1'b1;
                                again = 1'b1;
                            end
                        end
                        rpt_pkg::PH_OPT:
                        begin
                            emit = 1'b1;
                            again = c != rpt_pkg::CH_SEMI;
                        end
                        rpt_pkg::PH_MIN:
                        begin
                            if (q_data.is_dec)
                            begin
                                acc_next = adig(acc_next, q_data.digit);
                            end
                            else if (c == rpt_pkg::CH_STAR || c == rpt_pkg::CH_PLUS)
                            begin
                                min_next = acc_next;
                                phase_next = rpt_pkg::PH_MAX_START;
                            end
                            else
                            begin
                                min_next = acc_next;
                                max_next = acc_next;
                                emit = 1'b1;
                                again = c != rpt_pkg::CH_SEMI;
                            end
                        end
                        rpt_pkg::PH_MAX_START:
                        begin
                            if (q_data.is_dec)
                            begin
                                acc_next = adig('0, q_data.digit);
                                phase_next = rpt_pkg::PH_MAX;
                            end
                            else
                            begin
                                unb_next = 1'b1;
                                emit = 1'b1;
                                again = c != rpt_pkg::CH_SEMI;
                            end
                        end
                        rpt_pkg::PH_MAX:
                        begin
                            if (q_data.is_dec)
                            begin
                                acc_next = adig(acc_next, q_data.digit);
                            end
                            else
                            begin
                                max_next = acc_next;
                                emit = 1'b1;
                                again = c != rpt_pkg::CH_SEMI;
                            end
                        end
                        default:
                        begin
                            phase_next = rpt_pkg::PH_IDLE;
                            again = 1'b1;
                        end
                    endcase
                    if (emit)
                    begin
                        tk = '{kind_next, neg_next, w16o(start_next), w16o(len_next),
                               w16c(min_next), w16c(max_next), unb_next, 1'b0};
                        if (n == 2'd0)
                        begin
                            t0 = tk;
                        end
                        else
                        begin
                            t1 = tk;
                        end
                        n = n + 2'd1;
                        phase_next = rpt_pkg::PH_IDLE;
                        kind_next = '0;
                        neg_next = 1'b0;
                        start_next = '0;
                        len_next = '0;
                        depth_next = '0;
                        hex_next = 1'b0;
                        acc_next = '0;
                        min_next = COUNT_BITS'(1);
                        max_next = COUNT_BITS'(1);
                        unb_next = 1'b0;
                    end
                end
            end
        end
        nout = n;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= rpt_pkg::PH_IDLE;
            pos_reg <= '0;
            kind_reg <= '0;
            neg_reg <= 1'b0;
            start_reg <= '0;
            len_reg <= '0;
            depth_reg <= '0;
            hex_reg <= 1'b0;
            acc_reg <= '0;
            min_reg <= COUNT_BITS'(1);
            max_reg <= COUNT_BITS'(1);
            unb_reg <= 1'b0;
            cnt_reg <= 2'd0;
            rp_reg <= 1'b0;
        end
        else
        begin
            if (take)
            begin
                phase_reg <= phase_next;
                pos_reg <= pos_next;
                kind_reg <= kind_next;
                neg_reg <= neg_next;
                start_reg <= start_next;
                len_reg <= len_next;
                depth_reg <= depth_next;
                hex_reg <= hex_next;
                acc_reg <= acc_next;
                min_reg <= min_next;
                max_reg <= max_next;
                unb_reg <= unb_next;
            end
            if (take)
            begin
                cnt_reg <= cnt_reg - {1'b0, m_valid && m_ready} + nout;
                rp_reg <= 1'b0;
            end
            else if (m_valid && m_ready)
            begin
                cnt_reg <= cnt_reg - 2'd1;
                rp_reg <= !rp_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            buf_reg[0] <= t0;
            buf_reg[1] <= t1;
        end
    end
endmodule

[verif/tb_regex_pattern_tokenizer.sv]
// self-checking testbench for regex_pattern_tokenizer: directed and random patterns
// with a cycle-free token predictor; depends on rpt_pkg and the tokenizer rtl
`timescale 1ns / 1ps

module tb_regex_pattern_tokenizer;

    localparam int OFF_LIM = 65535;
    localparam int DEP_LIM = 255;
    localparam int CNT_LIM = 65535;

    typedef struct {
        logic [7:0] ch;
        logic       is_end;
        logic       drain;
    } pat_byte_t;

    typedef struct packed {
        logic [2:0]  kind;
        logic        neg;
        logic [15:0] start;
        logic [15:0] len;
        logic [15:0] mn;
        logic [15:0] mx;
        logic        unb;
        logic        last;
    } token_t;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata;
    logic        s_axis_tuser;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [71:0] m_axis_tdata;
    logic        m_axis_tlast;

    pat_byte_t pat_q[$];
    token_t    tok_q[$];
    int        errors = 0;
    int        sent = 0;
    int        accepted = 0;
    int        quiet_from = 0;
    bit        feed_done = 0;
    bit        in_fire = 0;
    int        tx_gap = 0;
    int        rx_gap = 0;
    int        rx_hold = 0;
    bit        hold_done = 0;

    // predictor state
    rpt_pkg::phase_t ph;
    int     pos_r, p_kind, p_neg, p_start, p_len, depth, hex_n, acc, p_min, p_max, p_unb;

    regex_pattern_tokenizer u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    initial clk = 0;
    always #10 clk = ~clk;

    function automatic int sat(input int a, input int b, input int lim);
        return (a + b > lim) ? lim : a + b;
    endfunction

    function automatic bit dec_c(input logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic bit hex_c(input logic [7:0] c);
        return dec_c(c) || (c >= "a" && c <= "f") || (c >= "A" && c <= "F");
    endfunction

    function automatic int add_digit(input int a, input logic [7:0] c);
        int v;
        v = a * 10 + (c - "0");
        return v > CNT_LIM ? CNT_LIM : v;
    endfunction

    task automatic clear_token();
        ph = rpt_pkg::PH_IDLE;
        p_kind = rpt_pkg::KIND_LIT; p_neg = 0; p_start = 0; p_len = 0; depth = 0; hex_n = 0;
        acc = 0; p_min = 1; p_max = 1; p_unb = 0;
    endtask

    task automatic push_token(input int k, input int n, input int s, input int l,
                              input int mn, input int mx, input int u, input bit lst);
        token_t t;
        t.kind = 3'(k); t.neg = 1'(n); t.start = 16'(s); t.len = 16'(l);
        t.mn = 16'(mn); t.mx = 16'(mx); t.unb = 1'(u); t.last = lst;
        tok_q.push_back(t);
    endtask

    task automatic emit_token(input bit lst);
        push_token(p_kind, p_neg, p_start, p_len, p_min, p_max, p_unb, lst);
        clear_token();
    endtask

    task automatic begin_base(input logic [7:0] c, input int p);
        p_start = p;
        case (c)
            rpt_pkg::CH_BSLASH:
            begin
                ph = rpt_pkg::PH_ESC; hex_n = 0;
            end
            rpt_pkg::CH_DOT, rpt_pkg::CH_DOLLAR:
            begin
                p_kind = (c == rpt_pkg::CH_DOT) ? rpt_pkg::KIND_ANY : rpt_pkg::KIND_END;
                p_len = 1; ph = rpt_pkg::PH_QUANT;
            end
            rpt_pkg::CH_LPAREN, rpt_pkg::CH_LBRACK:
            begin
                p_kind = (c == rpt_pkg::CH_LPAREN) ? rpt_pkg::KIND_GROUP
                                                   : rpt_pkg::KIND_CHOICE;
                p_start = sat(p, 1, OFF_LIM); p_len = 0; depth = 1; ph = rpt_pkg::PH_GROUP;
            end
            default:
            begin
                p_kind = rpt_pkg::KIND_LIT; p_len = 1; ph = rpt_pkg::PH_AFTER_LIT;
            end
        endcase
    endtask

    task automatic end_pattern();
        int dash_pos;
        dash_pos = pos_r > 0 ? pos_r - 1 : 0;
        case (ph)
            rpt_pkg::PH_IDLE: if (p_neg) push_token(rpt_pkg::KIND_LIT, 1, pos_r, 1, 1, 1, 0, 1);
            rpt_pkg::PH_ESC:
            begin
                if (hex_n == 0)
                begin
                    p_kind = rpt_pkg::KIND_END; p_len = 1;
                end
                emit_token(1);
            end
            rpt_pkg::PH_DASH:
            begin
                p_kind = rpt_pkg::KIND_LIT;
                emit_token(0);
                push_token(rpt_pkg::KIND_LIT, 0, dash_pos, 1, 1, 1, 0, 1);
            end
            rpt_pkg::PH_RANGE_ESC:
            begin
                if (hex_n == 0) p_len = sat(p_len, 2, OFF_LIM);
                emit_token(1);
            end
            rpt_pkg::PH_MIN:
            begin
                p_min = acc; p_max = acc; emit_token(1);
            end
            rpt_pkg::PH_MAX_START:
            begin
                p_unb = 1; emit_token(1);
            end
            rpt_pkg::PH_MAX:
            begin
                p_max = acc; emit_token(1);
            end
            default: emit_token(1);
        endcase
        clear_token();
        pos_r = 0;
    endtask

    task automatic tokenize_byte(input logic [7:0] c, input logic is_end);
        int  p;
        bit  again;
        logic [7:0] open_c, close_c;
        if (is_end)
        begin
            end_pattern();
            return;
        end
        p = pos_r;
        pos_r = sat(pos_r, 1, OFF_LIM);
        again = 1;
        while (again)
        begin
            again = 0;
            case (ph)
                rpt_pkg::PH_IDLE:
                    if (c == rpt_pkg::CH_CARET && !p_neg) p_neg = 1;
                    else begin_base(c, p);
                rpt_pkg::PH_ESC:
                    if (hex_n == 0)
                    begin
                        p_len = 2;
                        if (hex_c(c)) hex_n = 1;
                        else ph = rpt_pkg::PH_AFTER_LIT;
                    end
                    else if (hex_c(c))
                    begin
                        p_len = 3; ph = rpt_pkg::PH_AFTER_LIT;
                    end
                    else
                    begin
                        ph = rpt_pkg::PH_AFTER_LIT; again = 1;
                    end
                rpt_pkg::PH_GROUP:
                begin
                    open_c = (p_kind == rpt_pkg::KIND_GROUP) ? rpt_pkg::CH_LPAREN
                                                             : rpt_pkg::CH_LBRACK;
                    close_c = (p_kind == rpt_pkg::KIND_GROUP) ? rpt_pkg::CH_RPAREN
                                                              : rpt_pkg::CH_RBRACK;
                    if (c == rpt_pkg::CH_BSLASH)
                    begin
                        p_len = sat(p_len, 1, OFF_LIM); ph = rpt_pkg::PH_GROUP_ESC;
                    end
                    else if (c == open_c)
                    begin
                        depth = sat(depth, 1, DEP_LIM); p_len = sat(p_len, 1, OFF_LIM);
                    end
                    else if (c == close_c && depth <= 1)
                    begin
                        depth = 0; ph = rpt_pkg::PH_QUANT;
                    end
                    else
                    begin
                        if (c == close_c) depth--;
                        p_len = sat(p_len, 1, OFF_LIM);
                    end
                end
                rpt_pkg::PH_GROUP_ESC:
                begin
                    p_len = sat(p_len, 1, OFF_LIM); ph = rpt_pkg::PH_GROUP;
                end
                rpt_pkg::PH_AFTER_LIT:
                    if (c == rpt_pkg::CH_DASH)
                    begin
                        p_kind = rpt_pkg::KIND_RANGE; ph = rpt_pkg::PH_DASH;
                    end
                    else
                    begin
                        ph = rpt_pkg::PH_QUANT; again = 1;
                    end
                rpt_pkg::PH_DASH:
                    if (c == rpt_pkg::CH_BSLASH)
                    begin
                        ph = rpt_pkg::PH_RANGE_ESC; hex_n = 0;
                    end
                    else
                    begin
                        p_len = sat(p_len, 2, OFF_LIM); ph = rpt_pkg::PH_QUANT;
                    end
                rpt_pkg::PH_RANGE_ESC:
                    if (hex_n == 0)
                    begin
                        p_len = sat(p_len, 3, OFF_LIM);
                        if (hex_c(c)) hex_n = 1;
                        else ph = rpt_pkg::PH_QUANT;
                    end
                    else if (hex_c(c))
                    begin
                        p_len = sat(p_len, 1, OFF_LIM); ph = rpt_pkg::PH_QUANT;
                    end
                    else
                    begin
                        ph = rpt_pkg::PH_QUANT; again = 1;
                    end
                rpt_pkg::PH_QUANT:
                    if (c == rpt_pkg::CH_SEMI) emit_token(0);
                    else if (c == rpt_pkg::CH_QUEST)
                    begin
                        p_min = 0; ph = rpt_pkg::PH_OPT;
                    end
                    else if (dec_c(c))
                    begin
                        acc = add_digit(0, c); ph = rpt_pkg::PH_MIN;
                    end
                    else if (c == rpt_pkg::CH_STAR || c == rpt_pkg::CH_PLUS)
                    begin
                        if (c == rpt_pkg::CH_STAR) p_min = 0;
                        ph = rpt_pkg::PH_MAX_START;
                    end
                    else
                    begin
                        emit_token(0); again = 1;
                    end
                rpt_pkg::PH_OPT:
                begin
                    emit_token(0);
                    again = (c != rpt_pkg::CH_SEMI);
                end
                rpt_pkg::PH_MIN:
                    if (dec_c(c)) acc = add_digit(acc, c);
                    else if (c == rpt_pkg::CH_STAR || c == rpt_pkg::CH_PLUS)
                    begin
                        p_min = acc; ph = rpt_pkg::PH_MAX_START;
                    end
                    else
                    begin
                        p_min = acc; p_max = acc; emit_token(0);
                        again = (c != rpt_pkg::CH_SEMI);
                    end
                rpt_pkg::PH_MAX_START:
                    if (dec_c(c))
                    begin
                        acc = add_digit(0, c); ph = rpt_pkg::PH_MAX;
                    end
                    else
                    begin
                        p_unb = 1; emit_token(0);
                        again = (c != rpt_pkg::CH_SEMI);
                    end
                rpt_pkg::PH_MAX:
                    if (dec_c(c)) acc = add_digit(acc, c);
                    else
                    begin
                        p_max = acc; emit_token(0);
                        again = (c != rpt_pkg::CH_SEMI);
                    end
                default:
                begin
                    clear_token(); again = 1;
                end
            endcase
        end
    endtask

    // stimulus helpers
    task automatic add_byte(input logic [7:0] c, input logic e = 0, input logic d = 0);
        pat_byte_t b;
        b.ch = c; b.is_end = e; b.drain = d;
        pat_q.push_back(b);
    endtask

    task automatic add_text(input string s);
        for (int i = 0; i < s.len(); i++) add_byte(s[i]);
        add_byte(8'h00, 1);
    endtask

    function automatic logic [7:0] hex_digit();
        logic [7:0] t[] = '{"0", "9", "a", "f", "A", "F", "3", "c"};
        return t[$urandom_range(0, 7)];
    endfunction

    function automatic logic [7:0] plain_byte();
        logic [7:0] c;
        c = 8'($urandom_range(0, 255));
        if (c inside {rpt_pkg::CH_BSLASH, rpt_pkg::CH_LPAREN, rpt_pkg::CH_LBRACK,
                      rpt_pkg::CH_CARET, rpt_pkg::CH_DOT, rpt_pkg::CH_DOLLAR})
            c = "q";
        return c;
    endfunction

    task automatic add_escape();
        add_byte(rpt_pkg::CH_BSLASH);
        case ($urandom_range(0, 2))
            0: add_byte(hex_digit());
            1:
            begin
                add_byte(hex_digit()); add_byte(hex_digit());
            end
            default: add_byte(plain_byte());
        endcase
    endtask

    task automatic add_number();
        int n;
        n = $urandom_range(1, 3);
        for (int i = 0; i < n; i++) add_byte(8'("0" + $urandom_range(0, 9)));
    endtask

    task automatic add_token();
        int n;
        if ($urandom_range(0, 4) == 0) add_byte(rpt_pkg::CH_CARET);
        case ($urandom_range(0, 7))
            0, 1: add_byte(plain_byte());
            2: add_escape();
            3: add_byte($urandom_range(0, 1) ? rpt_pkg::CH_DOT : rpt_pkg::CH_DOLLAR);
            4, 5:
            begin
                add_byte($urandom_range(0, 1) ? rpt_pkg::CH_LPAREN : rpt_pkg::CH_LBRACK);
                n = $urandom_range(0, 6);
                for (int i = 0; i < n; i++)
                    case ($urandom_range(0, 5))
                        0: add_byte(rpt_pkg::CH_LPAREN);
                        1: add_byte(rpt_pkg::CH_LBRACK);
                        2: add_byte(rpt_pkg::CH_BSLASH);
                        default: add_byte(8'($urandom_range(0, 255)));
                    endcase
                add_byte(rpt_pkg::CH_RPAREN); add_byte(rpt_pkg::CH_RBRACK);
            end
            default:
            begin
                add_byte(plain_byte()); add_byte(rpt_pkg::CH_DASH);
                if ($urandom_range(0, 2) == 0) add_escape();
                else add_byte(plain_byte());
            end
        endcase
        case ($urandom_range(0, 9))
            0: add_byte(rpt_pkg::CH_SEMI);
            1: add_byte(rpt_pkg::CH_QUEST);
            2: add_number();
            3:
            begin
                add_number();
                add_byte($urandom_range(0, 1) ? rpt_pkg::CH_STAR : rpt_pkg::CH_PLUS);
            end
            4:
            begin
                add_number(); add_byte(rpt_pkg::CH_PLUS); add_number();
            end
            5: add_byte($urandom_range(0, 1) ? rpt_pkg::CH_STAR : rpt_pkg::CH_PLUS);
            6:
            begin
                add_byte(rpt_pkg::CH_STAR); add_number();
            end
            default: ;
        endcase
        if ($urandom_range(0, 3) == 0) add_byte(rpt_pkg::CH_SEMI);
    endtask

    task automatic add_pattern();
        int n;
        n = $urandom_range(1, 5);
        for (int i = 0; i < n; i++)
            if ($urandom_range(0, 9) == 0) add_byte(8'($urandom_range(0, 255)));
            else add_token();
        add_byte(8'h00, 1);
    endtask

    initial
    begin
        int n;
        logic [7:0] noise;
        add_text("a");
        add_text("^");
        add_text("\\");
        add_text("a-");
        add_text("a-\\");
        add_text("(ab\\");
        add_text("[a(b");
        add_text(".*3;$+a?;b");
        add_text("\\41b\\g\\7-\\e5");
        add_text("[^]x]^(a(b)c)12+34;x*");
        add_text("^^q-z5;");
        add_byte(8'h00, 1);
        add_byte(8'hff); add_byte(8'h80, 1, 1);
        n = 0;
        while (pat_q.size() < 1100)
        begin
            if ($urandom_range(0, 7) == 0)
            begin
                noise = 8'($urandom_range(0, 255));
                add_byte(noise, $urandom_range(0, 5) == 0);
            end
            else
                add_pattern();
            if (pat_q.size() > 700 && n == 0)
            begin
                add_byte("x", 0, 1);
                n = 1;
            end
        end
        quiet_from = pat_q.size();
        while (pat_q.size() < quiet_from + 200) add_pattern();
        add_text("a99999999*123456789");
        for (int i = 0; i < 260; i++) add_byte(rpt_pkg::CH_LPAREN);
        for (int i = 0; i < 260; i++) add_byte(rpt_pkg::CH_RPAREN);
        add_byte(8'h00, 1);
        feed_done = 1;
    end

    initial
    begin
        rst_n = 0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1;
    end

    initial
    begin
        clear_token();
        pos_r = 0;
    end

    // sender
    always @(negedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= 8'h00;
            s_axis_tuser  <= 1'b0;
        end
        else if (!s_axis_tvalid || in_fire)
        begin
            if (tx_gap > 0)
            begin
                tx_gap <= tx_gap - 1;
                s_axis_tvalid <= 1'b0;
            end
            else if (pat_q.size() == 0 || (pat_q[0].drain && tok_q.size() != 0))
                s_axis_tvalid <= 1'b0;
            else if (sent < quiet_from && $urandom_range(0, 9) == 0 && !s_axis_tvalid)
            begin
                tx_gap <= $urandom_range(0, 7);
                s_axis_tvalid <= 1'b0;
            end
            else
            begin
                s_axis_tvalid <= 1'b1;
                s_axis_tdata  <= pat_q[0].ch;
                s_axis_tuser  <= pat_q[0].is_end;
                void'(pat_q.pop_front());
                sent <= sent + 1;
            end
        end
    end

    // receiver
    always @(negedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_axis_tready <= 1'b0;
        else if (rx_hold > 0)
        begin
            rx_hold <= rx_hold - 1;
            m_axis_tready <= 1'b0;
        end
        else if (!hold_done && accepted > 300)
        begin
            hold_done <= 1'b1;
            rx_hold <= 400;
            m_axis_tready <= 1'b0;
        end
        else if (rx_gap > 0)
        begin
            rx_gap <= rx_gap - 1;
            m_axis_tready <= 1'b0;
        end
        else if (sent < quiet_from && $urandom_range(0, 7) == 0)
        begin
            rx_gap <= $urandom_range(0, 7);
            m_axis_tready <= 1'b0;
        end
        else
            m_axis_tready <= 1'b1;
    end

    // monitor and checker
    always @(posedge clk)
    begin
        token_t      want;
        logic [71:0] want_data;
        in_fire <= rst_n && s_axis_tvalid && s_axis_tready;
        if (rst_n && s_axis_tvalid && s_axis_tready)
        begin
            tokenize_byte(s_axis_tdata, s_axis_tuser);
            accepted <= accepted + 1;
        end
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (tok_q.size() == 0)
            begin
                $display("%t unexpected token: expected none, actual %h last %b",
                         $time, m_axis_tdata, m_axis_tlast);
                errors <= errors + 1;
            end
            else
            begin
                want = tok_q.pop_front();
                // packed from bit 0 up, zero pad on top
                want_data = {3'd0, want.unb, want.mx, want.mn, want.len, want.start,
                             want.neg, want.kind};
                if (want_data !== m_axis_tdata || want.last !== m_axis_tlast)
                begin
                    $display("%t token mismatch: expected %h last %b, actual %h last %b",
                             $time, want_data, want.last, m_axis_tdata, m_axis_tlast);
                    errors <= errors + 1;
                end
            end
        end
    end

    initial
    begin
        wait (feed_done);
        wait (pat_q.size() == 0 && !s_axis_tvalid && tok_q.size() == 0);
        repeat (50) @(posedge clk);
        if (errors == 0 && tok_q.size() == 0)
            $display("regex_pattern_tokenizer verification clean");
        else
            $display("regex_pattern_tokenizer verification failed");
        $finish;
    end

    initial
    begin
        #20ms;
        $display("regex_pattern_tokenizer verification failed");
        $finish;
    end

endmodule
